[hdl/hop_commitment_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// hop_commitment_sequencer_macros.svh
// Assertion macros shared by the hop commitment sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef HOP_COMMITMENT_SEQUENCER_MACROS_SVH
`define HOP_COMMITMENT_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, clocked on clk, off during rst
`define HCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define HCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HCS_ASSERT_NOW(label, ante, cons, msg)
`define HCS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[hdl/hcs_pkg.sv]
// ----------------------------------------------------------------------------
// hcs_pkg
// Types, codes and helpers for the hop commitment sequencer.
// ----------------------------------------------------------------------------
package hcs_pkg;

  localparam int TAG_WIDTH_DEF = 32;
  localparam int EV_TAG_W      = 32;

  // event kinds
  localparam logic [2:0] KIND_PUBLISH    = 3'd0;
  localparam logic [2:0] KIND_WITHDRAW   = 3'd1;
  localparam logic [2:0] KIND_LOCK       = 3'd2;
  localparam logic [2:0] KIND_LAUNCH     = 3'd3;
  localparam logic [2:0] KIND_INVALIDATE = 3'd4;
  localparam logic [2:0] KIND_LANDING    = 3'd5;

  // reject / accept reasons
  localparam logic [3:0] RSN_OK            = 4'd0;
  localparam logic [3:0] RSN_ID_REQUIRED   = 4'd1;
  localparam logic [3:0] RSN_NOT_LOCKED    = 4'd2;
  localparam logic [3:0] RSN_HOLD_BAD      = 4'd3;
  localparam logic [3:0] RSN_READY_BAD     = 4'd4;
  localparam logic [3:0] RSN_ID_MISMATCH   = 4'd5;
  localparam logic [3:0] RSN_NO_REPLACE    = 4'd6;
  localparam logic [3:0] RSN_AFTER_LOCK    = 4'd7;
  localparam logic [3:0] RSN_NO_REDIRECT   = 4'd8;
  localparam logic [3:0] RSN_DELEGATED     = 4'd9;
  localparam logic [3:0] RSN_INVALID_MODE  = 4'd10;

  // reported mode codes
  localparam logic [2:0] CODE_GROUND    = 3'd0;
  localparam logic [2:0] CODE_READY     = 3'd1;
  localparam logic [2:0] CODE_COMMITTED = 3'd2;
  localparam logic [2:0] CODE_FLIGHT    = 3'd3;
  localparam logic [2:0] CODE_LANDED    = 3'd4;
  localparam logic [2:0] CODE_EMERGENCY = 3'd5;
  localparam logic [2:0] CODE_BAD       = 3'd7;

  // protection decision / reason
  localparam logic [1:0] DEC_MAY_PLAN    = 2'd0;
  localparam logic [1:0] DEC_CONTINUE    = 2'd1;
  localparam logic [1:0] DEC_INVALIDATED = 2'd2;

  localparam logic [1:0] PRS_NONE      = 2'd0;
  localparam logic [1:0] PRS_CONTINUES = 2'd1;
  localparam logic [1:0] PRS_CTX_BAD   = 2'd2;
  localparam logic [1:0] PRS_EMERGENCY = 2'd3;

  typedef enum logic [5:0] {
    MODE_GROUND    = 6'b000001,
    MODE_READY     = 6'b000010,
    MODE_COMMITTED = 6'b000100,
    MODE_FLIGHT    = 6'b001000,
    MODE_LANDED    = 6'b010000,
    MODE_EMERGENCY = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [2:0]          event_kind;
    logic                plan_tag_present;
    logic [EV_TAG_W-1:0] plan_tag;
    logic                segment_tag_present;
    logic [EV_TAG_W-1:0] segment_tag;
  } evt_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] reason;
    logic [2:0] new_mode;
    logic       may_publish;
    logic [1:0] protection_decision;
    logic [1:0] protection_reason;
  } res_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    case (m)
      MODE_GROUND:    c = CODE_GROUND;
      MODE_READY:     c = CODE_READY;
      MODE_COMMITTED: c = CODE_COMMITTED;
      MODE_FLIGHT:    c = CODE_FLIGHT;
      MODE_LANDED:    c = CODE_LANDED;
      MODE_EMERGENCY: c = CODE_EMERGENCY;
      default:        c = CODE_BAD;
    endcase
    return c;
  endfunction

endpackage

[hdl/hop_commitment_sequencer.sv]
// ----------------------------------------------------------------------------
// hop_commitment_sequencer
// Hop commitment mode tracker: checks each request against the mode and the
// held plan/segment tags, updates them and reports the protection decision.
// ----------------------------------------------------------------------------
// channel | payload | handshake          | direction
// evt     | evt_t   | evt_valid/evt_stall | request in
// res     | res_t   | res_valid/res_stall | result out, one per request
//
// One request per cycle while res_stall is low, via the input register, then
// the result register. The decision is one pass over the mode register and
// two tag compares. Reset puts the mode in ground hold with no tags held.
// res_stall holds the result register; a further request waits in the input
// register, and evt_stall rises only while both registers are full and held.
// ----------------------------------------------------------------------------
`include "hop_commitment_sequencer_macros.svh"

module hop_commitment_sequencer #(
  parameter int TAG_WIDTH = hcs_pkg::TAG_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          evt_valid,
  output logic          evt_stall,
  input  hcs_pkg::evt_t evt,
  output logic          res_valid,
  input  logic          res_stall,
  output hcs_pkg::res_t res
);
  import hcs_pkg::*;

  localparam int TagBits = (TAG_WIDTH < EV_TAG_W) ? TAG_WIDTH : EV_TAG_W;

  logic                 s1_valid;
  evt_t                 s1_evt;
  logic                 adv;

  mode_t                mode;
  mode_t                mode_next;
  logic                 held_plan_present;
  logic                 held_plan_present_next;
  logic [TAG_WIDTH-1:0] held_plan_tag;
  logic [TAG_WIDTH-1:0] held_plan_tag_next;
  logic                 held_segment_present;
  logic                 held_segment_present_next;
  logic [TAG_WIDTH-1:0] held_segment_tag;
  logic [TAG_WIDTH-1:0] held_segment_tag_next;

  logic [TAG_WIDTH-1:0] ev_plan;
  logic [TAG_WIDTH-1:0] ev_seg;
  logic                 seg_ok;
  logic                 plan_ok;
  logic [3:0]           reason;
  res_t                 res_next;

  assign adv       = s1_valid && (!res_valid || !res_stall);
  assign evt_stall = s1_valid && !adv;

  assign ev_plan = TAG_WIDTH'(s1_evt.plan_tag[TagBits-1:0]);
  assign ev_seg  = TAG_WIDTH'(s1_evt.segment_tag[TagBits-1:0]);

  assign seg_ok  = held_segment_present && s1_evt.segment_tag_present &&
                   (held_segment_tag == ev_seg);
  assign plan_ok = held_plan_present && s1_evt.plan_tag_present &&
                   (held_plan_tag == ev_plan);

  always_comb begin
    mode_next                 = mode;
    held_plan_present_next    = held_plan_present;
    held_plan_tag_next        = held_plan_tag;
    held_segment_present_next = held_segment_present;
    held_segment_tag_next     = held_segment_tag;
    reason                    = RSN_OK;
    case (mode)
      MODE_GROUND, MODE_READY, MODE_LANDED: begin
        if (s1_evt.event_kind == KIND_PUBLISH) begin
          if (!(s1_evt.plan_tag_present && s1_evt.segment_tag_present)) begin
            reason = RSN_ID_REQUIRED;
          end else begin
            mode_next                 = MODE_READY;
            held_plan_present_next    = 1'b1;
            held_plan_tag_next        = ev_plan;
            held_segment_present_next = 1'b1;
            held_segment_tag_next     = ev_seg;
          end
        end else if (s1_evt.event_kind == KIND_LAUNCH) begin
          reason = RSN_NOT_LOCKED;
        end else if (mode == MODE_READY && s1_evt.event_kind == KIND_WITHDRAW) begin
          if (!(seg_ok && plan_ok)) begin
            reason = RSN_ID_MISMATCH;
          end else begin
            mode_next                 = MODE_GROUND;
            held_plan_present_next    = 1'b0;
            held_plan_tag_next        = '0;
            held_segment_present_next = 1'b0;
            held_segment_tag_next     = '0;
          end
        end else if (mode == MODE_READY && s1_evt.event_kind == KIND_LOCK) begin
          if (!(seg_ok && plan_ok)) begin
            reason = RSN_ID_MISMATCH;
          end else begin
            mode_next = MODE_COMMITTED;
          end
        end else begin
          reason = (mode == MODE_READY) ? RSN_READY_BAD : RSN_HOLD_BAD;
        end
      end
      MODE_COMMITTED: begin
        if (s1_evt.event_kind == KIND_PUBLISH) begin
          reason = RSN_NO_REPLACE;
        end else if (s1_evt.event_kind == KIND_LAUNCH) begin
          if (!seg_ok) begin
            reason = RSN_ID_MISMATCH;
          end else begin
            mode_next = MODE_FLIGHT;
          end
        end else if (s1_evt.event_kind == KIND_INVALIDATE) begin
          mode_next = MODE_EMERGENCY;
        end else begin
          reason = RSN_AFTER_LOCK;
        end
      end
      MODE_FLIGHT: begin
        if (s1_evt.event_kind == KIND_LANDING) begin
          if (!seg_ok) begin
            reason = RSN_ID_MISMATCH;
          end else begin
            mode_next = MODE_LANDED;
          end
        end else if (s1_evt.event_kind == KIND_INVALIDATE) begin
          mode_next = MODE_EMERGENCY;
        end else begin
          reason = RSN_NO_REDIRECT;
        end
      end
      MODE_EMERGENCY: begin
        reason = RSN_DELEGATED;
      end
      default: begin
        reason = RSN_INVALID_MODE;
      end
    endcase
  end

  always_comb begin
    res_next                     = '0;
    res_next.accepted            = (reason == RSN_OK);
    res_next.reason              = reason;
    res_next.new_mode            = mode_code(mode_next);
    res_next.may_publish         = (mode_next == MODE_GROUND) || (mode_next == MODE_READY) ||
                                   (mode_next == MODE_LANDED);
    res_next.protection_decision = DEC_MAY_PLAN;
    res_next.protection_reason   = PRS_NONE;
    if (mode_next == MODE_COMMITTED || mode_next == MODE_FLIGHT) begin
      if (!held_plan_present_next || !held_segment_present_next) begin
        res_next.protection_decision = DEC_INVALIDATED;
        res_next.protection_reason   = PRS_CTX_BAD;
      end else begin
        res_next.protection_decision = DEC_CONTINUE;
        res_next.protection_reason   = PRS_CONTINUES;
      end
    end else if (mode_next == MODE_EMERGENCY) begin
      res_next.protection_decision = DEC_INVALIDATED;
      res_next.protection_reason   = PRS_EMERGENCY;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt_valid && !evt_stall) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && !evt_stall) begin
      s1_evt <= evt;
    end
  end

  // mode and held context
  always_ff @(posedge clk) begin
    if (rst) begin
      mode                 <= MODE_GROUND;
      held_plan_present    <= 1'b0;
      held_plan_tag        <= '0;
      held_segment_present <= 1'b0;
      held_segment_tag     <= '0;
    end else if (adv) begin
      mode                 <= mode_next;
      held_plan_present    <= held_plan_present_next;
      held_plan_tag        <= held_plan_tag_next;
      held_segment_present <= held_segment_present_next;
      held_segment_tag     <= held_segment_tag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

  `HCS_ASSERT_NEXT(a_s1_hold, s1_valid && !adv, s1_valid && $stable(s1_evt), "request lost while held")
  `HCS_ASSERT_NEXT(a_mode_report, adv, res.new_mode == mode_code(mode), "reported mode differs from register")
  `HCS_ASSERT_NEXT(a_reject_keeps, adv && !res_next.accepted, $stable(mode) && $stable(held_plan_tag) && $stable(held_segment_tag) && $stable(held_plan_present) && $stable(held_segment_present), "rejected request changed state")
  `HCS_ASSERT_NEXT(a_publish_ready, adv && res_next.accepted && s1_evt.event_kind == KIND_PUBLISH, mode == MODE_READY && held_plan_present && held_segment_present, "accepted publish did not arm")
  `HCS_ASSERT_NOW(a_accept_code, res_valid, res.accepted == (res.reason == RSN_OK), "accept flag disagrees with reason")

endmodule

[dv/tb_hop_commitment_sequencer.sv]
// ----------------------------------------------------------------------------
// tb_hop_commitment_sequencer
// Self-checking bench for the hop commitment sequencer. A short table of
// directed requests walks the mode graph and the reject paths, then random
// requests, mostly well-formed hop sequences, run against a bench-side mode
// tracker. Each result is compared field by field, in order, with random
// idling on both channels, one long output hold-off and two full drains.
// ----------------------------------------------------------------------------
module tb_hop_commitment_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import hcs_pkg::*;

  localparam int TW             = TAG_WIDTH_DEF;
  localparam int RANDOM_ITEMS   = 1450;
  localparam int EMERGENCY_TAIL = 12;
  localparam int LONG_HOLD      = 80;
  localparam int HOLD_AT        = 300;
  localparam int DRAIN_AT       = 800;
  localparam int DRAIN_CYCLES   = 10;
  localparam int QUIET_LIMIT    = 1000;
  localparam int MAX_REPORTS    = 10;

  localparam logic [2:0] KIND_OTHER_A = 3'd6;
  localparam logic [2:0] KIND_OTHER_B = 3'd7;

  localparam logic [EV_TAG_W-1:0] TAG_MASK =
    (TW >= EV_TAG_W) ? {EV_TAG_W{1'b1}} : EV_TAG_W'((64'd1 << TW) - 64'd1);
  localparam logic [EV_TAG_W-1:0] ONES = {EV_TAG_W{1'b1}};

  typedef struct {
    evt_t req;
    bit   typed;
    res_t want;
  } step_row_t;

  logic clk;
  logic rst       = 1'b1;
  logic evt_valid = 1'b0;
  logic evt_stall;
  evt_t evt       = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  // bench-side copy of the sequencer state
  logic [2:0]          sq_mode;
  logic                sq_plan_present;
  logic [EV_TAG_W-1:0] sq_plan;
  logic                sq_seg_present;
  logic [EV_TAG_W-1:0] sq_seg;

  res_t        pending_results[$];
  step_row_t   steps[$];
  bit          hold_req;
  int unsigned accepted_requests;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit [15:0]   reasons_seen;
  bit [7:0]    modes_seen;

  hop_commitment_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic bit ids_agree(evt_t r, bit need_plan);
    bit seg_ok;
    bit plan_ok;
    seg_ok  = sq_seg_present && r.segment_tag_present &&
              (sq_seg == (r.segment_tag & TAG_MASK));
    plan_ok = !need_plan || (sq_plan_present && r.plan_tag_present &&
              (sq_plan == (r.plan_tag & TAG_MASK)));
    return seg_ok && plan_ok;
  endfunction

  function automatic res_t advance_commitment(evt_t r);
    res_t       o;
    logic [3:0] why;
    logic [2:0] nxt;
    o   = '0;
    why = RSN_OK;
    nxt = sq_mode;
    case (sq_mode)
      CODE_GROUND, CODE_READY, CODE_LANDED: begin
        if (r.event_kind == KIND_PUBLISH) begin
          if (!(r.plan_tag_present && r.segment_tag_present)) begin
            why = RSN_ID_REQUIRED;
          end else begin
            nxt             = CODE_READY;
            sq_plan_present = 1'b1;
            sq_plan         = r.plan_tag & TAG_MASK;
            sq_seg_present  = 1'b1;
            sq_seg          = r.segment_tag & TAG_MASK;
          end
        end else if (r.event_kind == KIND_LAUNCH) begin
          why = RSN_NOT_LOCKED;
        end else if (sq_mode == CODE_READY && r.event_kind == KIND_WITHDRAW) begin
          if (!ids_agree(r, 1'b1)) begin
            why = RSN_ID_MISMATCH;
          end else begin
            nxt             = CODE_GROUND;
            sq_plan_present = 1'b0;
            sq_plan         = '0;
            sq_seg_present  = 1'b0;
            sq_seg          = '0;
          end
        end else if (sq_mode == CODE_READY && r.event_kind == KIND_LOCK) begin
          if (!ids_agree(r, 1'b1)) why = RSN_ID_MISMATCH;
          else nxt = CODE_COMMITTED;
        end else begin
          why = (sq_mode == CODE_READY) ? RSN_READY_BAD : RSN_HOLD_BAD;
        end
      end
      CODE_COMMITTED: begin
        if (r.event_kind == KIND_PUBLISH) begin
          why = RSN_NO_REPLACE;
        end else if (r.event_kind == KIND_LAUNCH) begin
          if (!ids_agree(r, 1'b0)) why = RSN_ID_MISMATCH;
          else nxt = CODE_FLIGHT;
        end else if (r.event_kind == KIND_INVALIDATE) begin
          nxt = CODE_EMERGENCY;
        end else begin
          why = RSN_AFTER_LOCK;
        end
      end
      CODE_FLIGHT: begin
        if (r.event_kind == KIND_LANDING) begin
          if (!ids_agree(r, 1'b0)) why = RSN_ID_MISMATCH;
          else nxt = CODE_LANDED;
        end else if (r.event_kind == KIND_INVALIDATE) begin
          nxt = CODE_EMERGENCY;
        end else begin
          why = RSN_NO_REDIRECT;
        end
      end
      CODE_EMERGENCY: why = RSN_DELEGATED;
      default:        why = RSN_INVALID_MODE;
    endcase
    sq_mode       = nxt;
    o.accepted    = (why == RSN_OK);
    o.reason      = why;
    o.new_mode    = sq_mode;
    o.may_publish = (sq_mode == CODE_GROUND) || (sq_mode == CODE_READY) ||
                    (sq_mode == CODE_LANDED);
    if (sq_mode == CODE_COMMITTED || sq_mode == CODE_FLIGHT) begin
      if (!sq_plan_present || !sq_seg_present) begin
        o.protection_decision = DEC_INVALIDATED;
        o.protection_reason   = PRS_CTX_BAD;
      end else begin
        o.protection_decision = DEC_CONTINUE;
        o.protection_reason   = PRS_CONTINUES;
      end
    end else if (sq_mode == CODE_EMERGENCY) begin
      o.protection_decision = DEC_INVALIDATED;
      o.protection_reason   = PRS_EMERGENCY;
    end
    return o;
  endfunction

  function automatic res_t mk_res(logic acc, logic [3:0] rsn, logic [2:0] md, logic mp,
                                  logic [1:0] dec, logic [1:0] prs);
    res_t o;
    o.accepted            = acc;
    o.reason              = rsn;
    o.new_mode            = md;
    o.may_publish         = mp;
    o.protection_decision = dec;
    o.protection_reason   = prs;
    return o;
  endfunction

  function automatic void add_row(logic [2:0] k, logic pp, logic [EV_TAG_W-1:0] pt,
                                  logic sp, logic [EV_TAG_W-1:0] st, bit typed, res_t want);
    step_row_t row;
    row.req.event_kind          = k;
    row.req.plan_tag_present    = pp;
    row.req.plan_tag            = pt;
    row.req.segment_tag_present = sp;
    row.req.segment_tag         = st;
    row.typed                   = typed;
    row.want                    = want;
    steps.push_back(row);
  endfunction

  function automatic logic [EV_TAG_W-1:0] pick_tag();
    logic [EV_TAG_W-1:0] t;
    case ($urandom_range(0, 7))
      0:       t = '0;
      1:       t = ONES;
      default: t = $urandom;
    endcase
    return t;
  endfunction

  function automatic evt_t random_noise();
    evt_t r;
    r.event_kind          = 3'($urandom_range(0, 7));
    r.plan_tag_present    = 1'($urandom_range(0, 1));
    r.plan_tag            = pick_tag();
    r.segment_tag_present = 1'($urandom_range(0, 1));
    r.segment_tag         = pick_tag();
    return r;
  endfunction

  function automatic evt_t fresh_publish();
    evt_t r;
    r.event_kind          = KIND_PUBLISH;
    r.plan_tag_present    = 1'b1;
    r.plan_tag            = pick_tag();
    r.segment_tag_present = 1'b1;
    r.segment_tag         = pick_tag();
    return r;
  endfunction

  function automatic evt_t held_request(logic [2:0] k);
    evt_t r;
    r.event_kind          = k;
    r.plan_tag_present    = sq_plan_present;
    r.plan_tag            = sq_plan;
    r.segment_tag_present = sq_seg_present;
    r.segment_tag         = sq_seg;
    return r;
  endfunction

  function automatic evt_t corrupt(evt_t r);
    case ($urandom_range(0, 3))
      0:       r.plan_tag[$urandom_range(0, EV_TAG_W - 1)] ^= 1'b1;
      1:       r.segment_tag[$urandom_range(0, EV_TAG_W - 1)] ^= 1'b1;
      2:       r.plan_tag_present = 1'b0;
      default: r.segment_tag_present = 1'b0;
    endcase
    return r;
  endfunction

  // mostly the next legal step of a hop, with broken copies and noise mixed in;
  // invalidate in committed or flight only when the run may end in emergency
  function automatic evt_t make_request(bit allow_emergency);
    evt_t        r;
    int unsigned roll;
    logic [2:0]  step_kind;
    roll      = $urandom_range(0, 99);
    r         = random_noise();
    step_kind = (sq_mode == CODE_COMMITTED) ? KIND_LAUNCH : KIND_LANDING;
    case (sq_mode)
      CODE_GROUND, CODE_LANDED: begin
        if (roll < 60) begin
          r = fresh_publish();
        end else if (roll < 70) begin
          r = fresh_publish();
          if (roll[0]) r.plan_tag_present = 1'b0;
          else r.segment_tag_present = 1'b0;
        end
      end
      CODE_READY: begin
        if (roll < 35) r = held_request(KIND_LOCK);
        else if (roll < 50) r = held_request(KIND_WITHDRAW);
        else if (roll < 60) r = fresh_publish();
        else if (roll < 80) r = corrupt(held_request(roll[0] ? KIND_LOCK : KIND_WITHDRAW));
      end
      CODE_COMMITTED, CODE_FLIGHT: begin
        if (allow_emergency && roll < 50) begin
          r.event_kind = KIND_INVALIDATE;
        end else if (roll < 55) begin
          r = held_request(step_kind);
          r.plan_tag_present = 1'($urandom_range(0, 1));
        end else if (roll < 70) begin
          r = corrupt(held_request(step_kind));
        end
      end
      default: ;
    endcase
    if (!allow_emergency && (sq_mode == CODE_COMMITTED || sq_mode == CODE_FLIGHT) &&
        r.event_kind == KIND_INVALIDATE)
      r.event_kind = $urandom_range(0, 1) ? KIND_OTHER_A : KIND_OTHER_B;
    return r;
  endfunction

  function automatic int unsigned pick_idle(bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic drive_request(evt_t e, bit typed, res_t want);
    int unsigned idle;
    bit          quiet;
    res_t        predicted;
    quiet = hold_req || ((accepted_requests % 500) inside {[200:259]});
    idle  = pick_idle(quiet);
    @(negedge clk);
    if (idle != 0) begin
      evt_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    evt       <= e;
    evt_valid <= 1'b1;
    @(posedge clk);
    while (evt_stall) @(posedge clk);
    accepted_requests++;
    predicted = advance_commitment(e);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // output side: random stalls, a quiet stretch, and one long hold-off on request
  initial begin : receiver
    int unsigned n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
        res_stall <= 1'b0;
      end else begin
        n = pick_idle((accepted_requests % 500) inside {[380:439]});
        if (n == 0) begin
          res_stall <= 1'b0;
        end else begin
          res_stall <= 1'b1;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t  want;
    string bad;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      reasons_seen[res.reason] = 1'b1;
      modes_seen[res.new_mode] = 1'b1;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no request outstanding: %p", $realtime, res);
      end else begin
        want = pending_results.pop_front();
        bad  = "";
        if (res.accepted !== want.accepted) bad = {bad, " accepted"};
        if (res.reason !== want.reason) bad = {bad, " reason"};
        if (res.new_mode !== want.new_mode) bad = {bad, " new_mode"};
        if (res.may_publish !== want.may_publish) bad = {bad, " may_publish"};
        if (res.protection_decision !== want.protection_decision) bad = {bad, " decision"};
        if (res.protection_reason !== want.protection_reason) bad = {bad, " prot_reason"};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result %0d differs in%s: expected %p, got %p",
                     $realtime, results_seen, bad, want, res);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (evt_valid && !evt_stall) || (res_valid && !res_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no traffic for %0d cycles, %0d results outstanding",
                 $realtime, quiet_cycles, pending_results.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : sender
    sq_mode         = CODE_GROUND;
    sq_plan_present = 1'b0;
    sq_plan         = '0;
    sq_seg_present  = 1'b0;
    sq_seg          = '0;

    add_row(KIND_LAUNCH, 0, '0, 0, '0, 1,
            mk_res(0, RSN_NOT_LOCKED, CODE_GROUND, 1, DEC_MAY_PLAN, PRS_NONE));
    add_row(KIND_OTHER_A, 0, '0, 0, '0, 1,
            mk_res(0, RSN_HOLD_BAD, CODE_GROUND, 1, DEC_MAY_PLAN, PRS_NONE));
    add_row(KIND_OTHER_B, 1, ONES, 1, ONES, 1,
            mk_res(0, RSN_HOLD_BAD, CODE_GROUND, 1, DEC_MAY_PLAN, PRS_NONE));
    add_row(KIND_PUBLISH, 1, ONES, 0, ONES, 1,
            mk_res(0, RSN_ID_REQUIRED, CODE_GROUND, 1, DEC_MAY_PLAN, PRS_NONE));
    add_row(KIND_PUBLISH, 0, ONES, 1, ONES, 1,
            mk_res(0, RSN_ID_REQUIRED, CODE_GROUND, 1, DEC_MAY_PLAN, PRS_NONE));
    add_row(KIND_INVALIDATE, 1, ONES, 1, ONES, 1,
            mk_res(0, RSN_HOLD_BAD, CODE_GROUND, 1, DEC_MAY_PLAN, PRS_NONE));
    add_row(KIND_PUBLISH, 1, ONES, 1, ONES, 1,
            mk_res(1, RSN_OK, CODE_READY, 1, DEC_MAY_PLAN, PRS_NONE));
    add_row(KIND_INVALIDATE, 1, ONES, 1, ONES, 1,
            mk_res(0, RSN_READY_BAD, CODE_READY, 1, DEC_MAY_PLAN, PRS_NONE));
    add_row(KIND_LAUNCH, 1, ONES, 1, ONES, 1,
            mk_res(0, RSN_NOT_LOCKED, CODE_READY, 1, DEC_MAY_PLAN, PRS_NONE));
    add_row(KIND_WITHDRAW, 1, 32'hFFFF_FFFE, 1, ONES, 0, '0);
    add_row(KIND_LOCK, 0, ONES, 1, ONES, 0, '0);
    add_row(KIND_LOCK, 1, ONES, 1, ONES, 1,
            mk_res(1, RSN_OK, CODE_COMMITTED, 0, DEC_CONTINUE, PRS_CONTINUES));
    add_row(KIND_PUBLISH, 1, ONES, 1, ONES, 1,
            mk_res(0, RSN_NO_REPLACE, CODE_COMMITTED, 0, DEC_CONTINUE, PRS_CONTINUES));
    add_row(KIND_LANDING, 1, ONES, 1, ONES, 0, '0);
    add_row(KIND_LAUNCH, 1, ONES, 1, 32'h7FFF_FFFF, 0, '0);
    add_row(KIND_LAUNCH, 0, '0, 1, ONES, 0, '0);
    add_row(KIND_WITHDRAW, 1, ONES, 1, ONES, 0, '0);
    add_row(KIND_LANDING, 1, ONES, 0, ONES, 0, '0);
    add_row(KIND_LANDING, 0, '0, 1, ONES, 0, '0);
    add_row(KIND_LOCK, 1, ONES, 1, ONES, 0, '0);
    add_row(KIND_PUBLISH, 1, '0, 1, '0, 0, '0);
    add_row(KIND_WITHDRAW, 1, '0, 1, '0, 0, '0);
    add_row(KIND_PUBLISH, 1, 32'hA5A5_A5A5, 1, 32'h5A5A_5A5A, 0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (steps[i]) drive_request(steps[i].req, steps[i].typed, steps[i].want);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == DRAIN_AT) begin
        @(negedge clk);
        evt_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      drive_request(make_request(1'b0), 1'b0, '0);
    end

    // emergency is terminal, so it closes the run
    while (sq_mode != CODE_EMERGENCY) drive_request(make_request(1'b1), 1'b0, '0);
    repeat (EMERGENCY_TAIL) drive_request(make_request(1'b1), 1'b0, '0);

    @(negedge clk);
    evt_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("%0d requests (%0d directed), %0d results checked, %0d mismatches",
             accepted_requests, steps.size(), results_seen, mismatches);
    $display("reason codes seen %b, modes seen %b", reasons_seen, modes_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[hop_commitment_sequencer.f]
+incdir+hdl
hdl/hcs_pkg.sv
hdl/hop_commitment_sequencer.sv
dv/tb_hop_commitment_sequencer.sv
